// ===== rtl/shv_pkg.sv =====
`timescale 1ns / 1ps

package shv_pkg;

  // Register reset values and sizes
  localparam logic [31:0] MAGIC_RESET      = 32'hDCDC_F5F5;
  localparam logic [11:0] SCAN_LIMIT_RESET = 12'd2048;
  localparam int          MAX_VARINT_BYTES = 10;
  localparam int          CFG_DATA_W       = 32;

  // Configuration register indexes
  localparam logic CFG_MAGIC      = 1'b0;
  localparam logic CFG_SCAN_LIMIT = 1'b1;

  // Bounds on the fourth and fifth counts
  localparam logic [63:0] LEN_BOUND  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] DATA_BOUND = 64'h0000_0100_0000_0000;

  // Header parse phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MAGIC = 3'd1,
    PH_LEN   = 3'd2,
    PH_SKIP  = 3'd3,
    PH_STR   = 3'd4,
    PH_VAR   = 3'd5
  } phase_t;

  // Verdict codes
  typedef enum logic [2:0] {
    REASON_OK         = 3'd0,
    REASON_MAGIC      = 3'd1,
    REASON_FAULT      = 3'd2,
    REASON_UNTERM     = 3'd3,
    REASON_LONG_ULEB  = 3'd4,
    REASON_ZERO_COUNT = 3'd5,
    REASON_LEN_BOUND  = 3'd6,
    REASON_DATA_BOUND = 3'd7
  } reason_t;

  // Sticky value-check flags
  typedef struct packed {
    logic data_bad;
    logic len_bad;
    logic zero_bad;
  } check_flags_t;

  // One verdict
  typedef struct packed {
    logic    is_data;
    logic [63:0] total_length;
    reason_t reject_reason;
  } verdict_t;

endpackage

// ===== rtl/snapshot_header_validator_unit.sv =====
`timescale 1ns / 1ps

// A verdict is registered when the byte that decides it is accepted.
// Throughput: one byte per cycle while in_stall is low; one parse step per byte.
// A two-entry result buffer (output register plus skid) lets bytes flow while a
// verdict waits; in_stall rises only when both entries hold a verdict.
// Reset (rst, synchronous): parser waits for a start mark, buffer empty,
// registers back to magic 0xDCDCF5F5 and scan limit 2048.
module snapshot_header_validator_unit #(
  parameter int MAX_VARINT_BYTES = shv_pkg::MAX_VARINT_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          start_req,
  input  logic                          fault,
  // verdict channel
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic                          is_data,
  output logic [63:0]                   total_length,
  output logic [2:0]                    reject_reason,
  // configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [shv_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IdxW = $clog2(MAX_VARINT_BYTES + 1);

  // Configuration registers
  logic [31:0] magic_word;
  logic [11:0] version_scan_limit;

  // Parse state
  shv_pkg::phase_t       phase, phase_next;
  logic [11:0]           position_count, position_count_next;
  logic [63:0]           length_field, length_field_next;
  logic [63:0]           varint_accum, varint_accum_next;
  logic [IdxW-1:0]       varint_byte_index, varint_byte_index_next;
  logic [2:0]            varint_number, varint_number_next;
  shv_pkg::check_flags_t check_flags, check_flags_next;
  logic [31:0]           magic_shift, magic_shift_next;

  // Result buffer
  shv_pkg::verdict_t res_q, skid_q, verdict_new;
  logic              skid_valid;
  logic              hit;

  logic accept;
  logic take;

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~in_stall;
  assign take     = res_valid & ~res_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word         <= shv_pkg::MAGIC_RESET;
      version_scan_limit <= shv_pkg::SCAN_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shv_pkg::CFG_MAGIC:      magic_word         <= cfg_data[31:0];
        shv_pkg::CFG_SCAN_LIMIT: version_scan_limit <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // One parse step per byte
  always_comb begin
    shv_pkg::phase_t       ph;
    logic [11:0]           pos;
    logic [63:0]           len;
    logic [IdxW-1:0]       idx;
    logic [2:0]            num;
    shv_pkg::check_flags_t flg;
    logic [31:0]           msh;
    logic [63:0]           acc;
    logic [5:0]            sh;
    logic [12:0]           pos_inc;
    shv_pkg::reason_t      reason;

    // a start mark clears the candidate
    ph  = start_req ? shv_pkg::PH_MAGIC : phase;
    pos = start_req ? '0 : position_count;
    len = start_req ? '0 : length_field;
    acc = start_req ? '0 : varint_accum;
    idx = start_req ? '0 : varint_byte_index;
    num = start_req ? '0 : varint_number;
    flg = start_req ? '0 : check_flags;
    msh = start_req ? '0 : magic_shift;

    phase_next             = ph;
    position_count_next    = pos;
    length_field_next      = len;
    varint_accum_next      = acc;
    varint_byte_index_next = idx;
    varint_number_next     = num;
    check_flags_next       = flg;
    magic_shift_next       = msh;

    hit     = 1'b0;
    reason  = shv_pkg::REASON_OK;
    sh      = 6'(7 * int'(idx));
    pos_inc = 13'(pos) + 13'd1;

    if (ph != shv_pkg::PH_IDLE) begin
      if (fault) begin
        hit    = 1'b1;
        reason = shv_pkg::REASON_FAULT;
      end else begin
        case (ph)
          shv_pkg::PH_MAGIC: begin
            magic_shift_next    = {data_byte, msh[31:8]};
            position_count_next = pos_inc[11:0];
            if (pos_inc >= 13'd4) begin
              position_count_next = '0;
              if (magic_shift_next != magic_word) begin
                hit    = 1'b1;
                reason = shv_pkg::REASON_MAGIC;
              end else begin
                phase_next = shv_pkg::PH_LEN;
              end
            end
          end
          shv_pkg::PH_LEN: begin
            length_field_next[8*pos[2:0] +: 8] = data_byte;
            position_count_next = pos_inc[11:0];
            if (pos_inc >= 13'd8) begin
              phase_next          = shv_pkg::PH_SKIP;
              position_count_next = '0;
            end
          end
          shv_pkg::PH_SKIP: begin
            position_count_next = pos_inc[11:0];
            if (pos_inc >= 13'd8) begin
              phase_next          = shv_pkg::PH_STR;
              position_count_next = '0;
            end
          end
          shv_pkg::PH_STR: begin
            if (data_byte == 8'd0) begin
              phase_next             = shv_pkg::PH_VAR;
              varint_accum_next      = '0;
              varint_byte_index_next = '0;
              varint_number_next     = '0;
            end else if (pos_inc >= {1'b0, version_scan_limit}) begin
              hit    = 1'b1;
              reason = shv_pkg::REASON_UNTERM;
            end else begin
              position_count_next = pos_inc[11:0];
            end
          end
          shv_pkg::PH_VAR: begin
            varint_accum_next = acc | (64'(data_byte[6:0]) << sh);
            if (data_byte[7]) begin
              // continuation byte
              varint_byte_index_next = idx + 1'b1;
              if ((IdxW+1)'(idx) + 1'b1 >= (IdxW+1)'(MAX_VARINT_BYTES)) begin
                hit    = 1'b1;
                reason = shv_pkg::REASON_LONG_ULEB;
              end
            end else begin
              // value complete: record its check
              if (num < 3'd3) begin
                if (varint_accum_next == '0) check_flags_next.zero_bad = 1'b1;
              end else if (num == 3'd3) begin
                if (varint_accum_next > shv_pkg::LEN_BOUND) check_flags_next.len_bad = 1'b1;
              end else begin
                if (varint_accum_next > shv_pkg::DATA_BOUND) check_flags_next.data_bad = 1'b1;
              end
              varint_number_next     = num + 3'd1;
              varint_accum_next      = '0;
              varint_byte_index_next = '0;
              if (num == 3'd4) begin
                hit = 1'b1;
                if (check_flags_next.zero_bad)      reason = shv_pkg::REASON_ZERO_COUNT;
                else if (check_flags_next.len_bad)  reason = shv_pkg::REASON_LEN_BOUND;
                else if (check_flags_next.data_bad) reason = shv_pkg::REASON_DATA_BOUND;
                else                                reason = shv_pkg::REASON_OK;
              end
            end
          end
          default: phase_next = shv_pkg::PH_IDLE;
        endcase
      end
    end

    if (hit) phase_next = shv_pkg::PH_IDLE;

    verdict_new.is_data       = (reason == shv_pkg::REASON_OK);
    verdict_new.total_length  = (ph >= shv_pkg::PH_SKIP) ? len + 64'd4 : '0;
    verdict_new.reject_reason = reason;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= shv_pkg::PH_IDLE;
      position_count    <= '0;
      length_field      <= '0;
      varint_accum      <= '0;
      varint_byte_index <= '0;
      varint_number     <= '0;
      check_flags       <= '0;
      magic_shift       <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      position_count    <= position_count_next;
      length_field      <= length_field_next;
      varint_accum      <= varint_accum_next;
      varint_byte_index <= varint_byte_index_next;
      varint_number     <= varint_number_next;
      check_flags       <= check_flags_next;
      magic_shift       <= magic_shift_next;
    end
  end

  // Result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept & hit;
      end
    end else if (accept && hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !res_valid) begin
      if (skid_valid) res_q <= skid_q;
      else if (accept && hit) res_q <= verdict_new;
    end else if (accept && hit) begin
      skid_q <= verdict_new;
    end
  end

  assign is_data       = res_q.is_data;
  assign total_length  = res_q.total_length;
  assign reject_reason = res_q.reject_reason;

endmodule

// ===== rtl/shv_checker.sv =====
`timescale 1ns / 1ps

module shv_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic        is_data,
  input logic [63:0] total_length,
  input logic [2:0]  reject_reason
);

  // a stalled verdict holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(total_length) && $stable(reject_reason))
    else $error("stalled verdict changed");

  // byte side stalls only while a verdict is waiting
  assert property (@(posedge clk) disable iff (rst) in_stall |-> res_valid)
    else $error("input stalled with empty result register");

  // stall rises only after a verdict was held back
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(res_valid && res_stall))
    else $error("input stall without back-pressure");

  // pass flag agrees with the reason code
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (is_data == (reject_reason == shv_pkg::REASON_OK)))
    else $error("is_data disagrees with reject_reason");

  // nothing pending straight after reset
  assert property (@(posedge clk) $past(rst) |-> !res_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule

bind snapshot_header_validator_unit shv_checker u_shv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .is_data       (is_data),
  .total_length  (total_length),
  .reject_reason (reject_reason)
);
